FILE: rtl/bmmn_pkg.sv
package bmmn_pkg;

  localparam int DATA_W        = 8;
  localparam int MAX_BLOCK_DEF = 64;
  // quotient bits resolved per divider cycle
  localparam int DIV_BITS_CYC  = 2;
  localparam int DIV_CYC       = DATA_W / DIV_BITS_CYC;

  typedef struct packed {
    logic load;   // item accepted
    logic rd;     // read stored byte at emit index
    logic start;  // launch division for the byte just read
    logic emit;   // register result, advance emit index
  } bmmn_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_last;
  } bmmn_sts_t;

endpackage

FILE: rtl/bmmn_div.sv
module bmmn_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [2*bmmn_pkg::DATA_W-1:0] dividend,
  input  logic [bmmn_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [bmmn_pkg::DATA_W-1:0]   quotient
);
  import bmmn_pkg::*;

  localparam int CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] low_r, low_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;

  // restoring division, DIV_BITS_CYC bits per cycle; dividend high half < divisor
  always_comb begin
    logic [DATA_W:0]   t;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] l;
    logic [DATA_W-1:0] q;
    r = rem_r;
    l = low_r;
    q = q_r;
    for (int i = 0; i < DIV_BITS_CYC; i++) begin
      t = {r, l[DATA_W-1]};
      l = {l[DATA_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        q = {q[DATA_W-2:0], 1'b1};
      end else begin
        q = {q[DATA_W-2:0], 1'b0};
      end
      r = t[DATA_W-1:0];
    end
    rem_nxt = r;
    low_nxt = l;
    q_nxt   = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_CYC - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*DATA_W-1:DATA_W];
      low_r <= dividend[DATA_W-1:0];
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/bmmn_ctrl.sv
module bmmn_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  block_end,
  input  bmmn_pkg::bmmn_sts_t   sts,
  output bmmn_pkg::bmmn_cmd_t   cmd,
  output logic                  busy
);
  import bmmn_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_READ  = 4'b0010,
    S_START = 4'b0100,
    S_DIV   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (block_end) state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.is_last ? S_LOAD : S_READ;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/bmmn_datapath.sv
module bmmn_datapath #(
  parameter int MAX_BLOCK = bmmn_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmmn_pkg::bmmn_cmd_t         cmd,
  input  logic [bmmn_pkg::DATA_W-1:0] data_byte,
  output bmmn_pkg::bmmn_sts_t         sts,
  output logic                        out_valid,
  output logic [bmmn_pkg::DATA_W-1:0] out_scaled_byte,
  output logic                        out_final_out
);
  import bmmn_pkg::*;

  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CW = $clog2(MAX_BLOCK + 1);

  logic [DATA_W-1:0]   mem [MAX_BLOCK];
  logic [DATA_W-1:0]   rdata_r;
  logic [CW-1:0]       fill_r;
  logic [AW-1:0]       rd_idx_r;
  logic [DATA_W-1:0]   min_r, max_r;
  logic                valid_r;
  logic [DATA_W-1:0]   scaled_r;
  logic                final_r;

  logic                store_ok;
  logic                is_last;
  logic [DATA_W-1:0]   diff;
  logic [DATA_W-1:0]   span;
  logic [2*DATA_W-1:0] dividend;
  logic                div_done;
  logic [DATA_W-1:0]   quot;

  assign store_ok = fill_r < CW'(MAX_BLOCK);
  assign is_last  = (CW'(rd_idx_r) + CW'(1)) == fill_r;
  assign diff     = rdata_r - min_r;
  assign span     = max_r - min_r;
  // diff * 255
  assign dividend = {diff, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, diff};

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) mem[fill_r[AW-1:0]] <= data_byte;
    if (cmd.rd) rdata_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_idx_r <= '0;
      min_r    <= '0;
      max_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.load && store_ok) begin
        fill_r <= fill_r + CW'(1);
        if (fill_r == '0) begin
          min_r <= data_byte;
          max_r <= data_byte;
        end else begin
          if (data_byte < min_r) min_r <= data_byte;
          if (data_byte > max_r) max_r <= data_byte;
        end
      end
      if (cmd.emit) begin
        if (is_last) begin
          rd_idx_r <= '0;
          fill_r   <= '0;
        end else begin
          rd_idx_r <= rd_idx_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      scaled_r <= (span == '0) ? '0 : quot;
      final_r  <= is_last;
    end
  end

  bmmn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (quot)
  );

  assign sts.div_done   = div_done;
  assign sts.is_last    = is_last;
  assign out_valid       = valid_r;
  assign out_scaled_byte = scaled_r;
  assign out_final_out   = final_r;

endmodule

FILE: rtl/block_min_max_normalize.sv
// Min-max normalizer. Bytes are taken one per cycle (start high while busy is
// low) and stored, MAX_BLOCK at most; further bytes of a block are dropped.
// The byte with in_block_end set raises busy from the next cycle, and every
// stored byte is then sent out in order as floor((v-min)*255/(max-min)), or 0
// for a flat block. Each result passes through a registered store read, the
// divider launch, a two-bit-per-cycle divider and a register for the result.
// out_valid is high for one cycle per result and the receiver cannot stall
// it; out_final_out marks the last one, and busy drops in that same cycle,
// so the next block may start while it is shown.
module block_min_max_normalize #(
  parameter int MAX_BLOCK = bmmn_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bmmn_pkg::DATA_W-1:0] in_data_byte,
  input  logic                        in_block_end,
  output logic                        out_valid,
  output logic [bmmn_pkg::DATA_W-1:0] out_scaled_byte,
  output logic                        out_final_out
);
  import bmmn_pkg::*;

  bmmn_cmd_t cmd;
  bmmn_sts_t sts;

  bmmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .block_end (in_block_end),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  bmmn_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .data_byte       (in_data_byte),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_scaled_byte (out_scaled_byte),
    .out_final_out   (out_final_out)
  );

  a_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_block_end) |=> !busy)
    else $error("busy after item without block end");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_block_end) |=> busy)
    else $error("no emission after block end");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_out) |-> busy)
    else $error("input open before last result");

  a_last_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_out) |-> !busy)
    else $error("busy still high with last result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmmn_pkg::*;

  localparam int MAX_BLOCK   = MAX_BLOCK_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_ITEMS  = 250;

  typedef struct {
    logic [DATA_W-1:0] scaled;
    logic              last;
  } scaled_res_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] in_data_byte;
  logic              in_block_end;
  logic              out_valid;
  logic [DATA_W-1:0] out_scaled_byte;
  logic              out_final_out;

  // normalizer shadow state
  logic [DATA_W-1:0] byte_store [MAX_BLOCK];
  logic [6:0]        blk_count;
  logic [DATA_W-1:0] blk_min;
  logic [DATA_W-1:0] blk_max;
  logic              blk_dropped;

  scaled_res_t pending_scaled [$];

  int  fail_count;
  int  stall_cycles;
  int  items_sent;
  int  blocks_done;
  int  results_checked;
  int  flat_blocks;
  int  overfull_blocks;
  bit  no_idle;

  block_min_max_normalize #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data_byte   (in_data_byte),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_scaled_byte(out_scaled_byte),
    .out_final_out  (out_final_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic take_byte(input logic [DATA_W-1:0] b, input logic last);
    int          span;
    int          diff;
    int          i;
    scaled_res_t r;
    if (blk_count < MAX_BLOCK) begin
      if (blk_count == 0) begin
        blk_min = b;
        blk_max = b;
      end else begin
        if (b < blk_min) blk_min = b;
        if (b > blk_max) blk_max = b;
      end
      byte_store[blk_count] = b;
      blk_count = blk_count + 7'd1;
    end else begin
      blk_dropped = 1'b1;
    end
    if (last) begin
      span = int'(blk_max) - int'(blk_min);
      for (i = 0; i < blk_count; i++) begin
        diff = int'(byte_store[i]) - int'(blk_min);
        r.scaled = (span == 0) ? '0 : DATA_W'((diff * 255) / span);
        r.last   = (i + 1 == blk_count);
        pending_scaled.push_back(r);
      end
      blocks_done++;
      if (span == 0) flat_blocks++;
      if (blk_dropped) overfull_blocks++;
      blk_dropped = 1'b0;
      blk_count   = '0;
    end
  endtask

  // accepted items feed the shadow model; results are checked against it
  always @(posedge clk) begin
    scaled_res_t r;
    stall_cycles++;
    if (rst_n && out_valid) begin
      stall_cycles = 0;
      if (pending_scaled.size() == 0) begin
        $error("unexpected result: scaled_byte %0d final_out %0b",
               out_scaled_byte, out_final_out);
        fail_count++;
      end else begin
        r = pending_scaled.pop_front();
        results_checked++;
        if (out_scaled_byte !== r.scaled) begin
          $error("scaled_byte mismatch: expected %0d, actual %0d", r.scaled, out_scaled_byte);
          fail_count++;
        end
        if (out_final_out !== r.last) begin
          $error("final_out mismatch: expected %0b, actual %0b", r.last, out_final_out);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      stall_cycles = 0;
      items_sent++;
      take_byte(in_data_byte, in_block_end);
    end
  end

  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
    if (!no_idle && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    start        <= 1'b1;
    in_data_byte <= b;
    in_block_end <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_scaled.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_byte(input int mode, input int base,
                                                  input int spread);
    int v;
    case (mode)
      0, 1, 2, 3, 4, 5: v = $urandom_range(255);
      6, 7: begin
        v = base + $urandom_range(spread);
        if (v > 255) v = 255;
      end
      8: v = base;
      default: begin
        case ($urandom_range(2))
          0: v = 0;
          1: v = 255;
          default: v = $urandom_range(255);
        endcase
      end
    endcase
    return DATA_W'(v);
  endfunction

  task automatic test_single_byte();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  task automatic test_flat_block();
    repeat (3) send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_narrow_span();
    send_byte(8'd100, 1'b0);
    send_byte(8'd101, 1'b0);
    send_byte(8'd100, 1'b0);
    send_byte(8'd101, 1'b1);
  endtask

  // first byte is the block max; later bytes must only pull min down
  task automatic test_first_byte();
    send_byte(8'd240, 1'b0);
    send_byte(8'd30, 1'b0);
    send_byte(8'd90, 1'b1);
  endtask

  // bytes past a full store are dropped and must not move min/max
  task automatic test_store_full();
    int i;
    for (i = 0; i < MAX_BLOCK; i++) send_byte(DATA_W'($urandom_range(200, 50)), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_blocks();
    int  sent;
    int  len;
    int  mode;
    int  base;
    int  spread;
    int  i;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(99)) inside
        [0:79]:  len = $urandom_range(16, 1);
        [80:91]: len = $urandom_range(63, 17);
        default: len = $urandom_range(70, 64);
      endcase
      mode   = $urandom_range(9);
      base   = $urandom_range(255);
      spread = $urandom_range(7, 1);
      no_idle = (sent >= 150 && sent < 220);
      if (sent >= 100 && !paused) begin
        drain_results();
        repeat ($urandom_range(12, 1)) @(posedge clk);
        paused = 1'b1;
      end
      for (i = 0; i < len; i++) send_byte(pick_byte(mode, base, spread), i == len - 1);
      sent += len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data_byte = '0;
    in_block_end = 1'b0;
    blk_count    = '0;
    blk_min      = '0;
    blk_max      = '0;
    blk_dropped  = 1'b0;
    no_idle      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte();
    test_extremes();
    test_flat_block();
    test_narrow_span();
    test_first_byte();
    test_store_full();
    test_random_blocks();

    drain_results();
    repeat (40) @(posedge clk);

    $display("tb: %0d items in %0d blocks, %0d results checked", items_sent, blocks_done,
             results_checked);
    $display("tb: %0d flat blocks, %0d blocks with bytes dropped past a full store",
             flat_blocks, overfull_blocks);
    if (fail_count == 0 && pending_scaled.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bmmn_pkg.sv
rtl/bmmn_div.sv
rtl/bmmn_ctrl.sv
rtl/bmmn_datapath.sv
rtl/block_min_max_normalize.sv
tb/tb.sv
